// ===== design/afdd_pkg.sv =====
// Shared types and constants for the anchor-free detection row decoder.
// No dependencies; imported by anchor_free_detection_decode_top.
package afdd_pkg;

	localparam int VALUE_W   = 32;  // row element, signed Q16.16
	localparam int BOX_W     = 16;  // decoded box field
	localparam int SCORE_W   = 31;  // emitted best score
	localparam int CLASS_W   = 10;  // emitted best class
	localparam int LANES     = 4;   // left, top, width, height
	localparam int SPLIT_W   = 16;  // scale is split into two 16-bit halves
	localparam int CFG_AW    = 5;   // APB byte address width
	localparam int CFG_DW    = 32;

	localparam int CC_W      = 11;
	localparam int THR_W     = 17;
	localparam int SCALE_W   = 32;
	localparam int PAD_W     = 12;
	localparam int OFS_W     = 14;

	localparam int BOX_MAX   = 32767;
	localparam int BOX_MIN   = -32768;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_CLASS_COUNT = 3'd0;
	localparam logic [2:0] REG_THRESHOLD   = 3'd1;
	localparam logic [2:0] REG_INV_SCALE_X = 3'd2;
	localparam logic [2:0] REG_INV_SCALE_Y = 3'd3;
	localparam logic [2:0] REG_PAD_LEFT    = 3'd4;
	localparam logic [2:0] REG_PAD_TOP     = 3'd5;
	localparam logic [2:0] REG_OFFSET_X    = 3'd6;
	localparam logic [2:0] REG_OFFSET_Y    = 3'd7;

	// reset values
	localparam logic [CC_W-1:0]    RST_CLASS_COUNT = 11'd80;
	localparam logic [THR_W-1:0]   RST_THRESHOLD   = 17'd16384;
	localparam logic [SCALE_W-1:0] RST_INV_SCALE   = 32'd65536;

	// score and class that travel with a box through the decode pipeline
	typedef struct packed {
		logic [VALUE_W-1:0] score;
		logic [CLASS_W-1:0] cls;
	} afdd_tag_t;

endpackage

// ===== design/anchor_free_detection_decode_top.sv =====
// Anchor-free detection row decoder: score arg-max, threshold and box decode.
// Depends on afdd_pkg (types, register indexes, reset values).
// Path: a box for the last score of a row is registered through stages 1 to 4, then the output register.
// Throughput: one row word per cycle while in_ready is high; at most one box per row of clamped class count+4 words.
// Stalls: in_ready drops only while all five decode stages hold a box and out_ready is low.
// Reset (arst_n low): registers take their defaults, row position and pipeline valids clear.
module anchor_free_detection_decode_top
	import afdd_pkg::*;
#(
	parameter int MAX_CLASSES   = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [CFG_AW-1:0]          paddr,
	input  logic [CFG_DW-1:0]          pwdata,
	output logic [CFG_DW-1:0]          prdata,
	output logic                       pready,
	// row word input
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [VALUE_W-1:0]  row_value,
	// box output
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [BOX_W-1:0]    box_left,
	output logic signed [BOX_W-1:0]    box_top,
	output logic signed [BOX_W-1:0]    box_width,
	output logic signed [BOX_W-1:0]    box_height,
	output logic [SCORE_W-1:0]         best_score,
	output logic [CLASS_W-1:0]         best_class
);

	// Row position counts 0..MAX_CLASSES+3: four box words, then the scores.
	localparam int POS_W  = $clog2(MAX_CLASSES + 4);
	// Doubled box terms: 2*cx - w - (pad << (F+1)) needs this many signed bits.
	localparam int A_W    = (FRACTION_BITS + 15 > 35) ? FRACTION_BITS + 15 : 35;
	localparam int PH_W   = A_W + SPLIT_W;           // magnitude times a 16-bit half
	localparam int Q_W    = PH_W + 1;                // sum of both partial products
	localparam int SH     = 2 * FRACTION_BITS - 15;  // drop to whole pixels (2F+1 frac bits - 16)
	localparam int WH_W   = Q_W - SH;
	localparam int FL_W   = WH_W + 2;
	localparam logic signed [FL_W-1:0] SAT_HI = FL_W'(BOX_MAX);
	localparam logic signed [FL_W-1:0] SAT_LO = FL_W'(BOX_MIN);

	// ------------------------------------------------------------------
	// Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
	// ------------------------------------------------------------------
	logic [CC_W-1:0]    class_count_q;
	logic [THR_W-1:0]   threshold_q;
	logic [SCALE_W-1:0] inv_scale_x_q;
	logic [SCALE_W-1:0] inv_scale_y_q;
	logic [PAD_W-1:0]   pad_left_q;
	logic [PAD_W-1:0]   pad_top_q;
	logic [OFS_W-1:0]   offset_x_q;
	logic [OFS_W-1:0]   offset_y_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= RST_CLASS_COUNT;
			threshold_q   <= RST_THRESHOLD;
			inv_scale_x_q <= RST_INV_SCALE;
			inv_scale_y_q <= RST_INV_SCALE;
			pad_left_q    <= '0;
			pad_top_q     <= '0;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_CLASS_COUNT: class_count_q <= pwdata[CC_W-1:0];
				REG_THRESHOLD:   threshold_q   <= pwdata[THR_W-1:0];
				REG_INV_SCALE_X: inv_scale_x_q <= pwdata[SCALE_W-1:0];
				REG_INV_SCALE_Y: inv_scale_y_q <= pwdata[SCALE_W-1:0];
				REG_PAD_LEFT:    pad_left_q    <= pwdata[PAD_W-1:0];
				REG_PAD_TOP:     pad_top_q     <= pwdata[PAD_W-1:0];
				REG_OFFSET_X:    offset_x_q    <= pwdata[OFS_W-1:0];
				REG_OFFSET_Y:    offset_y_q    <= pwdata[OFS_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CLASS_COUNT: prdata = {{(CFG_DW-CC_W){1'b0}}, class_count_q};
			REG_THRESHOLD:   prdata = {{(CFG_DW-THR_W){1'b0}}, threshold_q};
			REG_INV_SCALE_X: prdata = inv_scale_x_q;
			REG_INV_SCALE_Y: prdata = inv_scale_y_q;
			REG_PAD_LEFT:    prdata = {{(CFG_DW-PAD_W){1'b0}}, pad_left_q};
			REG_PAD_TOP:     prdata = {{(CFG_DW-PAD_W){1'b0}}, pad_top_q};
			REG_OFFSET_X:    prdata = {{(CFG_DW-OFS_W){1'b0}}, offset_x_q};
			REG_OFFSET_Y:    prdata = {{(CFG_DW-OFS_W){1'b0}}, offset_y_q};
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Stage k may load when empty or when the
	// stage after it can take its contents; stage 5 is the output register.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	assign rdy5     = !out_valid || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Row scan: hold the box words, track the running best score.
	// ------------------------------------------------------------------
	logic [POS_W-1:0]         pos_q;
	logic [VALUE_W-1:0]       cx_q, cy_q, w_q, h_q;
	logic [VALUE_W-1:0]       best_q;
	logic [CLASS_W-1:0]       best_cls_q;

	logic                     box_phase;
	logic [POS_W-1:0]         cls_pos;
	logic [POS_W+CLASS_W-1:0] cls_ext;
	logic [POS_W-1:0]         cnt_eff;
	logic                     better;
	logic                     last_word;
	logic [VALUE_W-1:0]       new_best;
	logic [CLASS_W-1:0]       new_cls;
	logic                     emit;

	always_comb begin
		box_phase = (pos_q < POS_W'(4));
		cls_pos   = pos_q - POS_W'(4);
		cls_ext   = {{CLASS_W{1'b0}}, cls_pos};
		// clamp class count to 1..MAX_CLASSES
		if (class_count_q == '0)
			cnt_eff = POS_W'(1);
		else if (32'(class_count_q) > 32'(MAX_CLASSES))
			cnt_eff = POS_W'(MAX_CLASSES);
		else
			cnt_eff = POS_W'(class_count_q);
		// first score always loads; later ones only when strictly greater
		better    = (pos_q == POS_W'(4)) || ($signed(row_value) > $signed(best_q));
		new_best  = better ? row_value : best_q;
		new_cls   = better ? cls_ext[CLASS_W-1:0] : best_cls_q;
		// at or past the last class ends the row, also after count was lowered
		last_word = !box_phase && (cls_pos >= cnt_eff - POS_W'(1));
		emit      = last_word &&
		            ($signed({new_best[VALUE_W-1], new_best}) >
		             $signed({{(VALUE_W+1-THR_W){1'b0}}, threshold_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last_word ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (box_phase) begin
				unique case (pos_q[1:0])
					2'd0:    cx_q <= row_value;
					2'd1:    cy_q <= row_value;
					2'd2:    w_q  <= row_value;
					default: h_q  <= row_value;
				endcase
			end else begin
				best_q     <= new_best;
				best_cls_q <= new_cls;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: doubled box terms with the pads taken off (one fraction bit
	// more than the input). Held words are settled by the time a score ends a row.
	// ------------------------------------------------------------------
	logic [A_W-1:0] cx_x, cy_x, w_x, h_x, padl_x, padt_x;
	logic [A_W-1:0] a_next [LANES];
	logic [A_W-1:0] a_s1   [LANES];
	afdd_tag_t      tag_s1;

	always_comb begin
		cx_x   = {{(A_W-VALUE_W){cx_q[VALUE_W-1]}}, cx_q};
		cy_x   = {{(A_W-VALUE_W){cy_q[VALUE_W-1]}}, cy_q};
		w_x    = {{(A_W-VALUE_W){w_q[VALUE_W-1]}}, w_q};
		h_x    = {{(A_W-VALUE_W){h_q[VALUE_W-1]}}, h_q};
		padl_x = {{(A_W-PAD_W){1'b0}}, pad_left_q} << (FRACTION_BITS + 1);
		padt_x = {{(A_W-PAD_W){1'b0}}, pad_top_q} << (FRACTION_BITS + 1);
		a_next[0] = (cx_x << 1) - w_x - padl_x;
		a_next[1] = (cy_x << 1) - h_x - padt_x;
		a_next[2] = w_x << 1;
		a_next[3] = h_x << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= in_valid && emit;
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			a_s1         <= a_next;
			tag_s1.score <= new_best;
			tag_s1.cls   <= new_cls;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: split into sign and magnitude.
	// ------------------------------------------------------------------
	logic           neg_s2 [LANES];
	logic [A_W-1:0] mag_s2 [LANES];
	afdd_tag_t      tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int i = 0; i < LANES; i++) begin
				neg_s2[i] <= a_s1[i][A_W-1];
				mag_s2[i] <= a_s1[i][A_W-1] ? (~a_s1[i] + A_W'(1)) : a_s1[i];
			end
			tag_s2 <= tag_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: magnitude times each 16-bit half of the reciprocal scale.
	// Left and width use the x scale, top and height the y scale.
	// ------------------------------------------------------------------
	logic [SCALE_W-1:0] scale_lane [LANES];
	logic [PH_W-1:0]    p_hi_nx    [LANES];
	logic [PH_W-1:0]    p_lo_nx    [LANES];
	logic [PH_W-1:0]    p_hi_s3    [LANES];
	logic [A_W-1:0]     p_lo_hi_s3 [LANES];
	logic               lo_nz_s3   [LANES];
	logic               neg_s3     [LANES];
	afdd_tag_t          tag_s3;

	always_comb begin
		scale_lane[0] = inv_scale_x_q;
		scale_lane[1] = inv_scale_y_q;
		scale_lane[2] = inv_scale_x_q;
		scale_lane[3] = inv_scale_y_q;
		for (int i = 0; i < LANES; i++) begin
			p_hi_nx[i] = PH_W'(mag_s2[i]) * PH_W'(scale_lane[i][SCALE_W-1:SPLIT_W]);
			p_lo_nx[i] = PH_W'(mag_s2[i]) * PH_W'(scale_lane[i][SPLIT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int i = 0; i < LANES; i++) begin
				p_hi_s3[i]    <= p_hi_nx[i];
				p_lo_hi_s3[i] <= p_lo_nx[i][PH_W-1:SPLIT_W];
				lo_nz_s3[i]   <= (p_lo_nx[i][SPLIT_W-1:0] != '0);
				neg_s3[i]     <= neg_s2[i];
			end
			tag_s3 <= tag_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: sum the halves, drop to whole pixels, floor with the sign.
	// ------------------------------------------------------------------
	logic [Q_W-1:0]  q_nx     [LANES];
	logic [WH_W-1:0] whole_nx [LANES];
	logic            frac_nx  [LANES];
	logic [FL_W-1:0] fl_nx    [LANES];
	logic [FL_W-1:0] fl_s4    [LANES];
	logic            frac_s4  [LANES];
	afdd_tag_t       tag_s4;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			q_nx[i]     = {1'b0, p_hi_s3[i]} + {{(Q_W-A_W){1'b0}}, p_lo_hi_s3[i]};
			whole_nx[i] = q_nx[i][Q_W-1:SH];
			frac_nx[i]  = lo_nz_s3[i] || (q_nx[i][SH-1:0] != '0);
			if (neg_s3[i])
				fl_nx[i] = ~{2'b00, whole_nx[i]} + FL_W'(1) - {{(FL_W-1){1'b0}}, frac_nx[i]};
			else
				fl_nx[i] = {2'b00, whole_nx[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (rdy4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			fl_s4   <= fl_nx;
			frac_s4 <= frac_nx;
			tag_s4  <= tag_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5 (output register): add the region offset, turn floor into
	// truncation toward zero, saturate to 16 bits.
	// ------------------------------------------------------------------
	logic [FL_W-1:0]  off_lane [LANES];
	logic [FL_W-1:0]  sum_nx   [LANES];
	logic [FL_W-1:0]  r_nx     [LANES];
	logic [BOX_W-1:0] sat_nx   [LANES];
	logic [BOX_W-1:0] box_q    [LANES];
	afdd_tag_t        tag_q;

	always_comb begin
		off_lane[0] = {{(FL_W-OFS_W){1'b0}}, offset_x_q};
		off_lane[1] = {{(FL_W-OFS_W){1'b0}}, offset_y_q};
		off_lane[2] = '0;
		off_lane[3] = '0;
		for (int i = 0; i < LANES; i++) begin
			sum_nx[i] = fl_s4[i] + off_lane[i];
			r_nx[i]   = (sum_nx[i][FL_W-1] && frac_s4[i]) ? sum_nx[i] + FL_W'(1) : sum_nx[i];
			if ($signed(r_nx[i]) > SAT_HI)
				sat_nx[i] = BOX_W'(BOX_MAX);
			else if ($signed(r_nx[i]) < SAT_LO)
				sat_nx[i] = BOX_W'(BOX_MIN);
			else
				sat_nx[i] = r_nx[i][BOX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (rdy5)
			out_valid <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			box_q <= sat_nx;
			tag_q <= tag_s4;
		end
	end

	assign box_left   = box_q[0];
	assign box_top    = box_q[1];
	assign box_width  = box_q[2];
	assign box_height = box_q[3];
	assign best_score = tag_q.score[SCORE_W-1:0];
	assign best_class = tag_q.cls;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// row position never runs past the last score of the widest row
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= 32'(MAX_CLASSES + 3))
		else $error("row position beyond last score");

	// the word that ends a row restarts the position count
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_word |=> pos_q == '0)
		else $error("row position not cleared after last score");

	// input stalls only when every stage is full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_valid && !out_ready))
		else $error("input stalled with room in the pipeline");

	// a box that newly fills an empty stage 1 must have come from an accepted row-ending word
	a_s1_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(accept && last_word && emit))
		else $error("stage 1 loaded without a row end");

endmodule
